@@ src/rtp_receiver_statistics_top_macros.svh @@
// Assertion macros shared by the RTP receiver statistics block.
`ifndef RTP_RECEIVER_STATISTICS_TOP_MACROS_SVH
`define RTP_RECEIVER_STATISTICS_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RTPSTAT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rtpstat: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define RTPSTAT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rtpstat: next-cycle check failed");

`endif

@@ src/rtpstat_pkg.sv @@
// Shared widths, constants and inter-module structs of the RTP receiver statistics block.
package rtpstat_pkg;

    localparam int SEQ_W     = 16;
    localparam int CNT_W     = 32;
    localparam int TS_W      = 32;
    localparam int TPM_W     = 10;
    localparam int FRAC_W    = 8;
    localparam int JMS_W     = 24;
    localparam int EXP_W     = CNT_W + 2;
    localparam int DIV_NUM_W = CNT_W + FRAC_W;
    localparam int DIV_DEN_W = CNT_W + 1;

    localparam logic [SEQ_W-1:0] SEQ_HALF  = 16'h8000;
    localparam logic [TPM_W-1:0] TPM_RESET = 10'd90;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [CNT_W-1:0] CUM_MAX   = 32'h7FFF_FFFF;
    localparam logic [CNT_W-1:0] CUM_MIN   = 32'h8000_0000;
    localparam logic [JMS_W-1:0] JMS_MAX   = '1;

    // Sequence tracker commands
    typedef struct packed {
        logic             upd;
        logic             clr;
        logic [SEQ_W-1:0] seq;
    } t_trk_ctl;

    // Sequence tracker state view
    typedef struct packed {
        logic [SEQ_W-1:0] first_seq;
        logic [SEQ_W-1:0] highest_seq;
        logic [SEQ_W-1:0] wrap_cycles;
        logic [SEQ_W-1:0] interval_first_seq;
        logic [SEQ_W-1:0] interval_wraps;
        logic [CNT_W-1:0] total_packets;
        logic [CNT_W-1:0] interval_packets;
    } t_trk_stat;

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ src/rtpstat_trk.sv @@
// Sequence number bookkeeping: first/highest sequence, wraps and packet counters.
module rtpstat_trk (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rtpstat_pkg::t_trk_ctl  i_ctl,
    output rtpstat_pkg::t_trk_stat o_stat
);
    import rtpstat_pkg::*;

    logic [SEQ_W-1:0] r_first_seq;
    logic [SEQ_W-1:0] r_highest_seq;
    logic [SEQ_W-1:0] r_wrap_cycles;
    logic [SEQ_W-1:0] r_int_first_seq;
    logic [SEQ_W-1:0] r_int_wraps;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] r_int_pkts;

    logic [SEQ_W-1:0] seq_base;
    logic [SEQ_W-1:0] seq_dist;
    logic             seq_newer;
    logic             seq_wrap;

    // Compare against the highest sequence, or against itself on the first word
    always_comb begin
        seq_base  = (r_total == '0) ? i_ctl.seq : r_highest_seq;
        seq_dist  = i_ctl.seq - seq_base;
        seq_newer = (seq_dist != '0) &&
                    ((seq_dist < SEQ_HALF) ||
                     ((seq_dist == SEQ_HALF) && (i_ctl.seq > seq_base)));
        seq_wrap  = seq_newer && (i_ctl.seq < seq_base);
    end

    // Advance on a packet, drop the interval on a report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_seq     <= '0;
            r_highest_seq   <= '0;
            r_wrap_cycles   <= '0;
            r_int_first_seq <= '0;
            r_int_wraps     <= '0;
            r_total         <= '0;
            r_int_pkts      <= '0;
        end else if (i_ctl.upd) begin
            if (r_total == '0) begin
                r_first_seq <= i_ctl.seq;
            end
            if (r_int_pkts == '0) begin
                r_int_first_seq <= i_ctl.seq;
            end
            r_highest_seq <= seq_newer ? i_ctl.seq : seq_base;
            if (seq_wrap) begin
                r_wrap_cycles <= r_wrap_cycles + SEQ_W'(1);
                r_int_wraps   <= r_int_wraps + SEQ_W'(1);
            end
            if (r_total != CNT_MAX) begin
                r_total <= r_total + CNT_W'(1);
            end
            if (r_int_pkts != CNT_MAX) begin
                r_int_pkts <= r_int_pkts + CNT_W'(1);
            end
        end else if (i_ctl.clr) begin
            r_int_first_seq <= '0;
            r_int_pkts      <= '0;
            r_int_wraps     <= '0;
        end
    end

    assign o_stat.first_seq          = r_first_seq;
    assign o_stat.highest_seq        = r_highest_seq;
    assign o_stat.wrap_cycles        = r_wrap_cycles;
    assign o_stat.interval_first_seq = r_int_first_seq;
    assign o_stat.interval_wraps     = r_int_wraps;
    assign o_stat.total_packets      = r_total;
    assign o_stat.interval_packets   = r_int_pkts;

endmodule

@@ src/rtpstat_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module rtpstat_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtpstat_pkg::t_div_req i_req,
    output rtpstat_pkg::t_div_rsp o_rsp
);
    import rtpstat_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_NUM_W);
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_NUM_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   trial_sub;
    logic                 fits;
    logic [DIV_DEN_W-1:0] n_rem;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        trial     = {r_rem, r_num[DIV_NUM_W-1]};
        trial_sub = trial - {1'b0, r_den};
        fits      = !trial_sub[DIV_DEN_W];
        n_rem     = fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    // Step count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

@@ src/rtp_receiver_statistics_top.sv @@
// Top level of the RTP receiver statistics block: sequencer, jitter datapath and result word.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------------------
//  input    | in        | i_valid / o_stall      | i_mode, i_seq, i_rtp_timestamp, i_arrival_time
//  result   | out       | o_valid / i_stall      | o_loss_fraction, o_loss_total,
//           |           |                        | o_extended_highest_seq, o_jitter_ms
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_ticks_per_ms
//
// A packet word steps through S_PKT_D, S_PKT_MAG, S_PKT_SUB and S_PKT_ACC, unless it is
// the first packet of the stream. A report word runs the 40-step divider once for fraction
// lost and once for jitter in milliseconds; the first run is skipped when the interval shows no loss.
// Synchronous active-low reset clears all counters, jitter and the result valid flag.
// A result held by i_stall does not block the next input word; a report that
// finishes while the result register is still full waits for it to drain.
`include "rtp_receiver_statistics_top_macros.svh"

module rtp_receiver_statistics_top #(
    parameter int JITTER_FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_mode,
    input  logic [rtpstat_pkg::SEQ_W-1:0]        i_seq,
    input  logic [rtpstat_pkg::TS_W-1:0]         i_rtp_timestamp,
    input  logic [rtpstat_pkg::TS_W-1:0]         i_arrival_time,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [rtpstat_pkg::FRAC_W-1:0]       o_loss_fraction,
    output logic signed [rtpstat_pkg::CNT_W-1:0] o_loss_total,
    output logic [rtpstat_pkg::CNT_W-1:0]        o_extended_highest_seq,
    output logic [rtpstat_pkg::JMS_W-1:0]        o_jitter_ms,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rtpstat_pkg::TPM_W-1:0]        i_cfg_ticks_per_ms
);
    import rtpstat_pkg::*;

    localparam int JW = TS_W + JITTER_FRAC_BITS;
    localparam int DW = JW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PKT_D,
        S_PKT_MAG,
        S_PKT_SUB,
        S_PKT_ACC,
        S_RPT_EXP,
        S_RPT_LOST,
        S_FRAC_GO,
        S_FRAC_WAIT,
        S_JIT_GO,
        S_JIT_WAIT,
        S_RPT_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [TPM_W-1:0]  r_tpm;
    logic [TS_W-1:0]   r_last_ts;
    logic [TS_W-1:0]   r_last_arr;
    logic [TS_W-1:0]   r_da;
    logic [TS_W-1:0]   r_dt;
    logic [TS_W-1:0]   r_d;
    logic [TS_W-1:0]   r_mag;
    logic [DW-1:0]     r_diff;
    logic [JW-1:0]     r_jitter;
    logic [EXP_W-1:0]  r_exp_i;
    logic [EXP_W-1:0]  r_exp_t;
    logic [CNT_W-1:0]  r_lost;
    logic [CNT_W-1:0]  r_cum;
    logic [FRAC_W-1:0] r_frac;
    logic [JMS_W-1:0]  r_jms;

    logic              r_out_valid;
    logic [FRAC_W-1:0] r_out_frac;
    logic [CNT_W-1:0]  r_out_cum;
    logic [CNT_W-1:0]  r_out_ext;
    logic [JMS_W-1:0]  r_out_jms;

    t_trk_ctl  trk_ctl;
    t_trk_stat trk_stat;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    logic             in_accept;
    logic             out_free;
    logic             frac_go;
    logic [TPM_W-1:0] tpm_eff;
    logic [DW-1:0]    jit_sum;
    logic [EXP_W:0]   lost_i;
    logic [EXP_W:0]   lost_t;
    logic [EXP_W-CNT_W+1:0] cum_top;
    logic [CNT_W-1:0] cum_sat;

    rtpstat_trk u_trk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (trk_ctl),
        .o_stat  (trk_stat)
    );

    rtpstat_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Handshakes
    assign in_accept   = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    // Tracker commands: update on a packet word, clear the interval when a report lands
    assign trk_ctl.upd = in_accept && !i_mode;
    assign trk_ctl.clr = (r_state == S_RPT_DONE) && out_free;
    assign trk_ctl.seq = i_seq;

    // Report arithmetic
    always_comb begin
        tpm_eff = (r_tpm == '0) ? TPM_W'(1) : r_tpm;
        jit_sum = {1'b0, r_jitter} + {{4{r_diff[DW-1]}}, r_diff[DW-1:4]};
        lost_i  = {r_exp_i[EXP_W-1], r_exp_i} - (EXP_W+1)'(trk_stat.interval_packets);
        lost_t  = {r_exp_t[EXP_W-1], r_exp_t} - (EXP_W+1)'(trk_stat.total_packets);
        frac_go = (trk_stat.interval_packets != '0) && !r_exp_i[EXP_W-1] &&
                  (r_exp_i != '0) && !lost_i[EXP_W] && (lost_i != '0);
        cum_top = lost_t[EXP_W:CNT_W-1];
        if (trk_stat.total_packets == '0) begin
            cum_sat = '0;
        end else if ((&cum_top) || !(|cum_top)) begin
            cum_sat = lost_t[CNT_W-1:0];
        end else begin
            cum_sat = lost_t[EXP_W] ? CUM_MIN : CUM_MAX;
        end
    end

    // Divider operands: fraction lost, then jitter in milliseconds
    always_comb begin
        div_req.start = (r_state == S_FRAC_GO) || (r_state == S_JIT_GO);
        if (r_state == S_FRAC_GO) begin
            div_req.num = {r_lost, {FRAC_W{1'b0}}};
            div_req.den = r_exp_i[DIV_DEN_W-1:0];
        end else begin
            div_req.num = DIV_NUM_W'(r_jitter[JW-1:JITTER_FRAC_BITS]);
            div_req.den = DIV_DEN_W'(tpm_eff);
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_mode) begin
                        n_state = S_RPT_EXP;
                    end else if (trk_stat.total_packets != '0) begin
                        n_state = S_PKT_D;
                    end
                end
            end
            S_PKT_D:     n_state = S_PKT_MAG;
            S_PKT_MAG:   n_state = S_PKT_SUB;
            S_PKT_SUB:   n_state = S_PKT_ACC;
            S_PKT_ACC:   n_state = S_IDLE;
            S_RPT_EXP:   n_state = S_RPT_LOST;
            S_RPT_LOST:  n_state = frac_go ? S_FRAC_GO : S_JIT_GO;
            S_FRAC_GO:   n_state = S_FRAC_WAIT;
            S_FRAC_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_JIT_GO;
                end
            end
            S_JIT_GO:    n_state = S_JIT_WAIT;
            S_JIT_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_RPT_DONE;
                end
            end
            S_RPT_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // State and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_RPT_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                r_out_frac  <= r_frac;
                r_out_cum   <= r_cum;
                r_out_ext   <= {trk_stat.wrap_cycles, trk_stat.highest_seq};
                r_out_jms   <= r_jms;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stream state: ticks per ms, last timestamps, jitter estimate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm      <= TPM_RESET;
            r_last_ts  <= '0;
            r_last_arr <= '0;
            r_jitter   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tpm <= i_cfg_ticks_per_ms;
            end
            if (trk_ctl.upd) begin
                r_last_ts  <= i_rtp_timestamp;
                r_last_arr <= i_arrival_time;
            end
            if (r_state == S_PKT_ACC) begin
                r_jitter <= jit_sum[JW-1:0];
            end
        end
    end

    // Working registers of the packet and report steps
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_da <= i_arrival_time - r_last_arr;
            r_dt <= i_rtp_timestamp - r_last_ts;
        end
        case (r_state)
            S_PKT_D:   r_d    <= r_da - r_dt;
            S_PKT_MAG: r_mag  <= r_d[TS_W-1] ? (TS_W'(0) - r_d) : r_d;
            S_PKT_SUB: r_diff <= {1'b0, r_mag, {JITTER_FRAC_BITS{1'b0}}} - {1'b0, r_jitter};
            S_RPT_EXP: begin
                r_exp_i <= EXP_W'({trk_stat.interval_wraps, trk_stat.highest_seq})
                         - EXP_W'(trk_stat.interval_first_seq) + EXP_W'(1);
                r_exp_t <= EXP_W'({trk_stat.wrap_cycles, trk_stat.highest_seq})
                         - EXP_W'(trk_stat.first_seq) + EXP_W'(1);
            end
            S_RPT_LOST: begin
                r_lost <= lost_i[CNT_W-1:0];
                r_cum  <= cum_sat;
                r_frac <= '0;
            end
            S_FRAC_WAIT: begin
                if (div_rsp.done) begin
                    r_frac <= div_rsp.quot[FRAC_W-1:0];
                end
            end
            S_JIT_WAIT: begin
                if (div_rsp.done) begin
                    r_jms <= (div_rsp.quot[DIV_NUM_W-1:JMS_W] != '0) ? JMS_MAX
                                                                     : div_rsp.quot[JMS_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid                = r_out_valid;
    assign o_loss_fraction        = r_out_frac;
    assign o_loss_total           = r_out_cum;
    assign o_extended_highest_seq = r_out_ext;
    assign o_jitter_ms            = r_out_jms;

    // Checks
    `RTPSTAT_ASSERT_IMP(a_stall_while_dividing, div_rsp.busy, o_stall)
    `RTPSTAT_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, (r_state == S_FRAC_WAIT) || (r_state == S_JIT_WAIT))
    `RTPSTAT_ASSERT_IMP(a_jitter_below_bound, r_state == S_PKT_ACC, !jit_sum[JW-1] && !r_jitter[JW-1])
    `RTPSTAT_ASSERT_NXT(a_interval_cleared, trk_ctl.clr, (trk_stat.interval_packets == '0) && r_out_valid)

endmodule

@@ bench/rtp_receiver_statistics_top_tb.sv @@
// Self-checking bench for the RTP receiver statistics block: stream predictor, driver, monitor.
module rtp_receiver_statistics_top_tb;
    import rtpstat_pkg::*;

    localparam int          JFRAC         = 8;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned SETTLE_CYCLES = 120;
    localparam int unsigned QUIET_LIMIT   = 4000;
    localparam int unsigned PHASE_WORDS   = 210;
    localparam int unsigned STORM_WORDS   = 240;
    localparam int unsigned STORM_REPORT  = 40;

    typedef enum logic {
        MODE_PACKET = 1'b0,
        MODE_REPORT = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode            mode;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  arr;
    } t_rtp_word;

    typedef struct packed {
        logic [FRAC_W-1:0] loss_fraction;
        logic [CNT_W-1:0]  loss_total;
        logic [CNT_W-1:0]  ext_high_seq;
        logic [JMS_W-1:0]  jitter_ms;
    } t_rr_report;

    // DUT ports
    logic                     i_clk;
    logic                     i_rst_n            = 1'b0;
    logic                     i_valid            = 1'b0;
    logic                     o_stall;
    logic                     i_mode             = 1'b0;
    logic [SEQ_W-1:0]         i_seq              = '0;
    logic [TS_W-1:0]          i_rtp_timestamp    = '0;
    logic [TS_W-1:0]          i_arrival_time     = '0;
    logic                     o_valid;
    logic                     i_stall            = 1'b0;
    logic [FRAC_W-1:0]        o_loss_fraction;
    logic signed [CNT_W-1:0]  o_loss_total;
    logic [CNT_W-1:0]         o_extended_highest_seq;
    logic [JMS_W-1:0]         o_jitter_ms;
    logic                     i_cfg_valid        = 1'b0;
    logic                     o_cfg_ready;
    logic [TPM_W-1:0]         i_cfg_ticks_per_ms = '0;

    // Predicted stream state
    logic [TPM_W-1:0] tpm_reg       = TPM_RESET;
    logic [SEQ_W-1:0] rx_first_seq  = '0;
    logic [SEQ_W-1:0] rx_high_seq   = '0;
    logic [SEQ_W-1:0] rx_wraps      = '0;
    logic [CNT_W-1:0] rx_total      = '0;
    logic [SEQ_W-1:0] ivl_first_seq = '0;
    logic [SEQ_W-1:0] ivl_wraps     = '0;
    logic [CNT_W-1:0] ivl_total     = '0;
    longint           jitter_q8     = 0;
    logic [TS_W-1:0]  last_ts       = '0;
    logic [TS_W-1:0]  last_arr      = '0;

    // Bench bookkeeping
    t_rtp_word    pending_words[$];
    t_rr_report   expected_reports[$];
    t_rtp_word    drv_word;
    t_rr_report   oldest_report;
    int unsigned  send_gap      = 0;
    int unsigned  hold_left     = 0;
    int unsigned  reports_seen  = 0;
    int unsigned  quiet_cycles  = 0;
    int unsigned  fail_count    = 0;
    bit           calm          = 1'b0;
    logic [SEQ_W-1:0] gen_seq;
    logic [TS_W-1:0]  gen_ts;
    logic [TS_W-1:0]  gen_arr;
    int unsigned  transit_amp;

    rtp_receiver_statistics_top #(
        .JITTER_FRAC_BITS(JFRAC)
    ) u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_mode                 (i_mode),
        .i_seq                  (i_seq),
        .i_rtp_timestamp        (i_rtp_timestamp),
        .i_arrival_time         (i_arrival_time),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_loss_fraction        (o_loss_fraction),
        .o_loss_total           (o_loss_total),
        .o_extended_highest_seq (o_extended_highest_seq),
        .o_jitter_ms            (o_jitter_ms),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_ticks_per_ms     (i_cfg_ticks_per_ms)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one; none while calm
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // a is ahead of b in sequence space; the exact half-way point goes to the larger value
    function automatic logic seq_ahead(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return (d != '0 && d < SEQ_HALF) || (d == SEQ_HALF && a > b);
    endfunction

    // Advance sequence tracking, counters and the interarrival jitter for one packet
    task automatic account_packet(input t_rtp_word w);
        logic [TS_W-1:0] d;
        longint          mag;
        longint          gap;
        if (ivl_total == '0) ivl_first_seq = w.seq;
        if (rx_total == '0) begin
            rx_first_seq = w.seq;
            rx_high_seq  = w.seq;
        end
        if (seq_ahead(w.seq, rx_high_seq)) begin
            if (w.seq < rx_high_seq) begin
                rx_wraps  = rx_wraps + 1'b1;
                ivl_wraps = ivl_wraps + 1'b1;
            end
            rx_high_seq = w.seq;
        end
        if (rx_total != '0) begin
            d   = (w.arr - last_arr) - (w.ts - last_ts);
            mag = d[TS_W-1] ? longint'(33'h1_0000_0000) - longint'(d) : longint'(d);
            gap = (mag << JFRAC) - jitter_q8;
            if (gap >= 0) begin
                jitter_q8 = jitter_q8 + (gap >>> 4);
            end else begin
                jitter_q8 = jitter_q8 - ((-gap + 15) >>> 4);
            end
        end
        last_ts  = w.ts;
        last_arr = w.arr;
        if (rx_total != CNT_MAX) rx_total = rx_total + 1'b1;
        if (ivl_total != CNT_MAX) ivl_total = ivl_total + 1'b1;
    endtask

    // Form the receiver report, then clear the interval
    function automatic t_rr_report close_interval();
        t_rr_report r;
        longint     want;
        longint     lost;
        longint     frac;
        longint     cum;
        longint     jms;
        longint     tpm_eff;
        frac = 0;
        cum  = 0;
        if (ivl_total != '0) begin
            want = longint'(ivl_wraps) * 65536 + longint'(rx_high_seq)
                 - longint'(ivl_first_seq) + 1;
            if (want >= 1 && longint'(ivl_total) < want) begin
                lost = want - longint'(ivl_total);
                frac = (lost << 8) / want;
                if (frac > 255) frac = 255;
            end
        end
        if (rx_total != '0) begin
            want = longint'(rx_wraps) * 65536 + longint'(rx_high_seq)
                 - longint'(rx_first_seq) + 1;
            cum  = want - longint'(rx_total);
            if (cum > longint'(CUM_MAX)) cum = longint'(CUM_MAX);
            if (cum < -longint'(CUM_MIN)) cum = -longint'(CUM_MIN);
        end
        tpm_eff = (tpm_reg == '0) ? 1 : longint'(tpm_reg);
        jms     = jitter_q8 / (tpm_eff << JFRAC);
        if (jms > longint'(JMS_MAX)) jms = longint'(JMS_MAX);
        r.loss_fraction = frac[FRAC_W-1:0];
        r.loss_total    = cum[CNT_W-1:0];
        r.ext_high_seq  = {rx_wraps, rx_high_seq};
        r.jitter_ms     = jms[JMS_W-1:0];
        ivl_first_seq = '0;
        ivl_total     = '0;
        ivl_wraps     = '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: hold the word while stalled, predict on acceptance, then idle or advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                if (drv_word.mode == MODE_REPORT) begin
                    expected_reports.push_back(close_interval());
                end else begin
                    account_packet(drv_word);
                end
            end
            if (!i_valid || !o_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    drv_word = pending_words.pop_front();
                    i_mode          <= drv_word.mode;
                    i_seq           <= drv_word.seq;
                    i_rtp_timestamp <= drv_word.ts;
                    i_arrival_time  <= drv_word.arr;
                    i_valid         <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each report word against the oldest prediction, drive random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("report word 0x%h with no report pending", o_extended_highest_seq);
                    fail_count++;
                end else begin
                    oldest_report = expected_reports.pop_front();
                    check_field("loss_fraction", CNT_W'(oldest_report.loss_fraction),
                                CNT_W'(o_loss_fraction));
                    check_field("loss_total", oldest_report.loss_total,
                                o_loss_total);
                    check_field("extended_highest_seq", oldest_report.ext_high_seq,
                                o_extended_highest_seq);
                    check_field("jitter_ms", CNT_W'(oldest_report.jitter_ms),
                                CNT_W'(o_jitter_ms));
                end
                reports_seen++;
                // Long hold-off so the block backs up and stalls its input
                if (reports_seen == 30 || reports_seen == 120) hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                hold_left = ($urandom_range(0, 1) != 0) ? pick_gap() : 0;
                if (hold_left != 0) begin
                    hold_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic push_word(input t_mode mode, input logic [SEQ_W-1:0] seq,
                             input logic [TS_W-1:0] ts, input logic [TS_W-1:0] arr);
        t_rtp_word w;
        w.mode = mode;
        w.seq  = seq;
        w.ts   = ts;
        w.arr  = arr;
        pending_words.push_back(w);
    endtask

    // Mostly an orderly stream with loss, duplicates and reordering; some reports and noise
    task automatic push_random(input int unsigned n);
        int unsigned r;
        int          step;
        logic [TS_W-1:0] tsd;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                push_word(MODE_REPORT, SEQ_W'($urandom), $urandom, $urandom);
            end else if (r < 84) begin
                r = $urandom_range(0, 99);
                if (r < 75) step = 1;
                else if (r < 85) step = $urandom_range(2, 20);
                else if (r < 90) step = 0;
                else if (r < 97) step = -int'($urandom_range(1, 4));
                else step = $urandom_range(100, 40000);
                tsd     = $urandom_range(0, 3200);
                gen_seq = gen_seq + SEQ_W'(step);
                gen_ts  = gen_ts + tsd;
                gen_arr = gen_arr + tsd + $urandom_range(0, 2 * transit_amp) - transit_amp;
                push_word(MODE_PACKET, gen_seq, gen_ts, gen_arr);
            end else begin
                push_word(MODE_PACKET, SEQ_W'($urandom), $urandom, $urandom);
            end
        end
    endtask

    task automatic write_ticks(input logic [TPM_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_ticks_per_ms <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tpm_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every word to be taken and every report to come back, then let the block go idle
    task automatic drain_and_settle();
        while (pending_words.size() != 0 || i_valid || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [TPM_W-1:0] tpm, input bit no_idle);
        write_ticks(tpm);
        calm        = no_idle;
        transit_amp = $urandom_range(0, 3000);
        push_random(PHASE_WORDS);
        drain_and_settle();
    endtask

    initial begin
        gen_seq     = SEQ_W'($urandom);
        gen_ts      = $urandom;
        gen_arr     = $urandom;
        transit_amp = 200;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty stream, sequence wrap, loss, late and duplicate packets,
        // half-space jumps both ways, extreme transit differences
        push_word(MODE_REPORT, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(MODE_PACKET, 16'hFFFF, 32'h0000_0000, 32'h0000_0000);
        push_word(MODE_PACKET, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(MODE_PACKET, 16'd6, 32'd640, 32'd100);
        push_word(MODE_PACKET, 16'd3, 32'd400, 32'd300);
        push_word(MODE_PACKET, 16'd6, 32'd800, 32'd900);
        push_word(MODE_REPORT, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        push_word(MODE_REPORT, 16'h5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        push_word(MODE_PACKET, 16'd32774, 32'd1000, 32'h8000_1000);
        push_word(MODE_PACKET, 16'd6, 32'd1100, 32'h0000_1000);
        push_word(MODE_PACKET, 16'd32775, 32'h7FFF_FFFF, 32'h0000_0000);
        push_word(MODE_PACKET, 16'd32776, 32'h0000_0000, 32'h7FFF_FFFF);
        push_word(MODE_REPORT, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        push_word(MODE_PACKET, 16'd32777, 32'h8000_0000, 32'h0000_0000);
        push_word(MODE_PACKET, 16'd32777, 32'h8000_0000, 32'h8000_0000);
        push_word(MODE_PACKET, 16'd40000, 32'hFFFF_0000, 32'h0000_FFFF);
        push_word(MODE_REPORT, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000);
        drain_and_settle();

        run_phase(10'd1, 1'b0);
        run_phase(10'd1000, 1'b1);
        run_phase(10'd0, 1'b0);
        run_phase(10'd1023, 1'b0);
        run_phase(TPM_W'($urandom_range(1, 1000)), 1'b1);
        run_phase(TPM_RESET, 1'b0);
        run_phase(TPM_W'($urandom_range(1, 1000)), 1'b0);
        run_phase(10'd2, 1'b0);

        // Wrap storm: near half-space steps pile up wrap cycles and loss quickly
        write_ticks(10'd1);
        calm = 1'b1;
        for (int unsigned k = 1; k <= STORM_WORDS; k++) begin
            gen_seq = gen_seq + 16'd32767;
            gen_ts  = gen_ts + 32'd160;
            gen_arr = gen_arr + 32'd160 + $urandom_range(0, 40);
            push_word(MODE_PACKET, gen_seq, gen_ts, gen_arr);
            if (k % STORM_REPORT == 0) begin
                push_word(MODE_REPORT, SEQ_W'($urandom), $urandom, $urandom);
            end
        end
        push_word(MODE_REPORT, SEQ_W'($urandom), $urandom, $urandom);
        drain_and_settle();

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/rtpstat_pkg.sv
src/rtpstat_trk.sv
src/rtpstat_div.sv
src/rtp_receiver_statistics_top.sv
bench/rtp_receiver_statistics_top_tb.sv
